/* hdl/ptp_pkg.sv */
// Shared types, codes and constants of the phase tick profiler.
`default_nettype none
package ptp_pkg;

   localparam int PHASES_DEF = 8;
   localparam logic [31:0] TPS_RESET = 32'd1000000;
   localparam logic [63:0] MS_Q16 = 64'd65536000;
   localparam logic [63:0] PCT_Q16 = 64'd6553600;
   localparam int NUM_W = 128;
   localparam int DEN_W = 64;
   localparam int Q_W = 48;

   typedef enum logic [0:0] {
      REG_TPS    = 1'b0,
      REG_PACING = 1'b1
   } reg_type;

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_PHASE   = 2'd1,
      KIND_SUMMARY = 2'd2
   } kind_type;

   typedef enum logic {
      OP_MUL = 1'b0,
      OP_DIV = 1'b1
   } op_type;

   typedef struct packed {
      logic   start;
      op_type op;
   } unit_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_ZERO_OUT,
      ST_DEN_MUL,
      ST_PH_MUL,
      ST_PH_DIV,
      ST_PH_OUT,
      ST_EL_DIV,
      ST_FPS_MUL,
      ST_FPS_DIV,
      ST_ACT_MUL,
      ST_ACT_DIV,
      ST_BUSY_MUL,
      ST_BUSY_DIV,
      ST_UNT_MUL,
      ST_UNT_DIV,
      ST_SUM_OUT
   } state_type;

endpackage
`default_nettype wire

/* hdl/phase_tick_profiler.sv */
// Top level of the phase tick profiler: phase store, sequencer and result register.
//
//  channel  direction  handshake             payload
//  req_     in         req_valid/req_stall   cmd, phase, ticks, presented, now
//  rsp_     out        rsp_valid/rsp_stall   kind, phase_index, six Q.16 figures, frame_total, last
//  csr_     in         csr_valid/csr_ready   index, data
//
// An accepted add request is written to the phase store if its phase is in range. An update
// without a sample goes through ST_DECIDE and gives its result from ST_ZERO_OUT. A sample runs
// the denominator, then each phase, then the summary figures through the bit-serial unit in turn.
// Reset is synchronous and clears the phase accumulators through their valid bits.
// A stalled result holds the sequencer; no request is taken until all results are gone.
`default_nettype none
module phase_tick_profiler import ptp_pkg::*; #(
   parameter int PHASES = PHASES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [3:0]  req_phase,
   input  logic [63:0] req_ticks,
   input  logic        req_presented,
   input  logic [63:0] req_now,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [3:0]  rsp_phase_index,
   output logic [47:0] rsp_phase_ms_q16,
   output logic [47:0] rsp_elapsed_s_q16,
   output logic [31:0] rsp_frame_total,
   output logic [47:0] rsp_fps_q16,
   output logic [47:0] rsp_active_ms_q16,
   output logic [47:0] rsp_busy_pct_q16,
   output logic [47:0] rsp_untracked_ms_q16,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int IW = (PHASES > 1) ? $clog2(PHASES) : 1;
   localparam int SW = 64 + $clog2(PHASES + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(PHASES - 1);

   state_type        state_ff, state_in;
   logic [31:0]      tps_ff;
   logic [3:0]       pacing_ff;
   logic [63:0]      begin_ff, begin_in, now_ff, now_in, elapsed_ff, elapsed_in;
   logic [63:0]      den_ff, den_in;
   logic [31:0]      frame_ff, frame_in;
   logic             pres_ff, pres_in;
   logic [63:0]      acc_ff [PHASES];
   logic [PHASES-1:0] vld_ff;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [SW-1:0]    tracked_ff, tracked_in, active_ff, active_in;
   logic [IW-1:0]    idx_ff, idx_in, rd_idx;
   logic [1:0]       kind_ff, kind_in;
   logic [3:0]       pidx_ff, pidx_in;
   logic [47:0]      pms_ff, pms_in, els_ff, els_in, fps_ff, fps_in;
   logic [47:0]      ams_ff, ams_in, bpct_ff, bpct_in, unt_ff, unt_in;
   logic [31:0]      ftot_ff, ftot_in;
   logic             last_ff, last_in;

   logic             req_acc, rsp_acc, acc_we, clear_all;
   logic [IW-1:0]    acc_waddr;
   logic [63:0]      acc_wdata, acc_rd, diff, untr;
   logic [64:0]      add_sum;
   logic [31:0]      frame_div;
   unit_ctl_type     uctl;
   unit_stat_type    ustat;
   logic [NUM_W-1:0] ua, uprod;
   logic [DEN_W-1:0] ub;
   logic [Q_W-1:0]   uquo;
   logic             ulaunch;

   assign req_acc = req_valid & ~req_stall;
   assign rsp_acc = rsp_valid & ~rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rd_idx = (state_ff == ST_IDLE) ? req_phase[IW-1:0] : idx_ff;
   assign acc_rd = vld_ff[rd_idx] ? acc_ff[rd_idx] : 64'd0;
   assign add_sum = {1'b0, acc_rd} + {1'b0, req_ticks};
   assign diff = now_ff - begin_ff;
   assign frame_div = (frame_ff == 32'd0) ? 32'd1 : frame_ff;
   assign untr = (tracked_ff >= SW'(elapsed_ff)) ? 64'd0 : (elapsed_ff - tracked_ff[63:0]);
   assign ulaunch = ~ustat.busy & ~ustat.done;

   ptp_unit u_unit (
      .clock    (clock),
      .reset    (reset),
      .ctl      (uctl),
      .a_in     (ua),
      .b_arg    (ub),
      .stat     (ustat),
      .prod_out (uprod),
      .quo_out  (uquo)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_cmd) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (tps_ff == 32'd0 || now_ff < begin_ff || diff < {32'd0, tps_ff}) begin
               state_in = ST_ZERO_OUT;
            end else begin
               state_in = ST_DEN_MUL;
            end
         end
         ST_ZERO_OUT: if (rsp_acc) state_in = ST_IDLE;
         ST_DEN_MUL:  if (ustat.done) state_in = ST_PH_MUL;
         ST_PH_MUL:   if (ustat.done) state_in = ST_PH_DIV;
         ST_PH_DIV:   if (ustat.done) state_in = ST_PH_OUT;
         ST_PH_OUT: begin
            if (rsp_acc) state_in = (idx_ff == LAST_IDX) ? ST_EL_DIV : ST_PH_MUL;
         end
         ST_EL_DIV:   if (ustat.done) state_in = ST_FPS_MUL;
         ST_FPS_MUL:  if (ustat.done) state_in = ST_FPS_DIV;
         ST_FPS_DIV:  if (ustat.done) state_in = ST_ACT_MUL;
         ST_ACT_MUL:  if (ustat.done) state_in = ST_ACT_DIV;
         ST_ACT_DIV:  if (ustat.done) state_in = ST_BUSY_MUL;
         ST_BUSY_MUL: if (ustat.done) state_in = ST_BUSY_DIV;
         ST_BUSY_DIV: if (ustat.done) state_in = ST_UNT_MUL;
         ST_UNT_MUL:  if (ustat.done) state_in = ST_UNT_DIV;
         ST_UNT_DIV:  if (ustat.done) state_in = ST_SUM_OUT;
         ST_SUM_OUT:  if (rsp_acc) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      begin_in = begin_ff;
      now_in = now_ff;
      pres_in = pres_ff;
      elapsed_in = elapsed_ff;
      den_in = den_ff;
      frame_in = frame_ff;
      num_in = num_ff;
      tracked_in = tracked_ff;
      active_in = active_ff;
      idx_in = idx_ff;
      kind_in = kind_ff;
      pidx_in = pidx_ff;
      pms_in = pms_ff;
      els_in = els_ff;
      fps_in = fps_ff;
      ams_in = ams_ff;
      bpct_in = bpct_ff;
      unt_in = unt_ff;
      ftot_in = ftot_ff;
      last_in = last_ff;
      acc_we = 1'b0;
      acc_waddr = req_phase[IW-1:0];
      acc_wdata = add_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : add_sum[63:0];
      clear_all = 1'b0;
      uctl.start = 1'b0;
      uctl.op = OP_MUL;
      ua = '0;
      ub = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (!req_cmd) begin
                  acc_we = (5'(req_phase) < 5'(PHASES));
               end else begin
                  now_in = req_now;
                  pres_in = req_presented;
               end
            end
         end
         ST_DECIDE: begin
            kind_in = KIND_NONE;
            pidx_in = '0;
            pms_in = '0;
            els_in = '0;
            fps_in = '0;
            ams_in = '0;
            bpct_in = '0;
            unt_in = '0;
            ftot_in = '0;
            last_in = 1'b1;
            elapsed_in = diff;
            tracked_in = '0;
            active_in = '0;
            idx_in = '0;
            if (tps_ff != 32'd0) begin
               if (now_ff < begin_ff) begin
                  clear_all = 1'b1;
                  begin_in = now_ff;
                  frame_in = '0;
               end else if (pres_ff && frame_ff != 32'hFFFF_FFFF) begin
                  frame_in = frame_ff + 32'd1;
               end
            end
         end
         ST_DEN_MUL: begin
            uctl.start = ulaunch;
            ua = NUM_W'(tps_ff);
            ub = DEN_W'(frame_div);
            if (ustat.done) den_in = uprod[63:0];
         end
         ST_PH_MUL: begin
            uctl.start = ulaunch;
            ua = NUM_W'(acc_rd);
            ub = MS_Q16;
            if (ustat.done) num_in = uprod;
         end
         ST_PH_DIV: begin
            uctl.start = ulaunch;
            uctl.op = OP_DIV;
            ua = num_ff;
            ub = den_ff;
            if (ustat.done) begin
               kind_in = KIND_PHASE;
               pidx_in = 4'(idx_ff);
               pms_in = uquo;
               last_in = 1'b0;
               tracked_in = tracked_ff + SW'(acc_rd);
               if (4'(idx_ff) != pacing_ff) active_in = active_ff + SW'(acc_rd);
            end
         end
         ST_PH_OUT: begin
            if (rsp_acc && idx_ff != LAST_IDX) idx_in = idx_ff + 1'b1;
         end
         ST_EL_DIV: begin
            uctl.start = ulaunch;
            uctl.op = OP_DIV;
            ua = {48'd0, elapsed_ff, 16'd0};
            ub = DEN_W'(tps_ff);
            if (ustat.done) els_in = uquo;
         end
         ST_FPS_MUL: begin
            uctl.start = ulaunch;
            ua = NUM_W'(frame_ff);
            ub = DEN_W'(tps_ff);
            if (ustat.done) num_in = uprod;
         end
         ST_FPS_DIV: begin
            uctl.start = ulaunch;
            uctl.op = OP_DIV;
            ua = {num_ff[NUM_W-17:0], 16'd0};
            ub = elapsed_ff;
            if (ustat.done) fps_in = uquo;
         end
         ST_ACT_MUL: begin
            uctl.start = ulaunch;
            ua = NUM_W'(active_ff);
            ub = MS_Q16;
            if (ustat.done) num_in = uprod;
         end
         ST_ACT_DIV: begin
            uctl.start = ulaunch;
            uctl.op = OP_DIV;
            ua = num_ff;
            ub = den_ff;
            if (ustat.done) ams_in = uquo;
         end
         ST_BUSY_MUL: begin
            uctl.start = ulaunch;
            ua = NUM_W'(active_ff);
            ub = PCT_Q16;
            if (ustat.done) num_in = uprod;
         end
         ST_BUSY_DIV: begin
            uctl.start = ulaunch;
            uctl.op = OP_DIV;
            ua = num_ff;
            ub = elapsed_ff;
            if (ustat.done) bpct_in = uquo;
         end
         ST_UNT_MUL: begin
            uctl.start = ulaunch;
            ua = NUM_W'(untr);
            ub = MS_Q16;
            if (ustat.done) num_in = uprod;
         end
         ST_UNT_DIV: begin
            uctl.start = ulaunch;
            uctl.op = OP_DIV;
            ua = num_ff;
            ub = den_ff;
            if (ustat.done) begin
               unt_in = uquo;
               kind_in = KIND_SUMMARY;
               pidx_in = '0;
               pms_in = '0;
               ftot_in = frame_ff;
               last_in = 1'b1;
            end
         end
         ST_SUM_OUT: begin
            if (rsp_acc) begin
               clear_all = 1'b1;
               begin_in = now_ff;
               frame_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      now_ff <= now_in;
      pres_ff <= pres_in;
      elapsed_ff <= elapsed_in;
      den_ff <= den_in;
      num_ff <= num_in;
      tracked_ff <= tracked_in;
      active_ff <= active_in;
      idx_ff <= idx_in;
      kind_ff <= kind_in;
      pidx_ff <= pidx_in;
      pms_ff <= pms_in;
      els_ff <= els_in;
      fps_ff <= fps_in;
      ams_ff <= ams_in;
      bpct_ff <= bpct_in;
      unt_ff <= unt_in;
      ftot_ff <= ftot_in;
      last_ff <= last_in;
      if (acc_we) acc_ff[acc_waddr] <= acc_wdata;
      if (reset) begin
         state_ff <= ST_IDLE;
         tps_ff <= TPS_RESET;
         pacing_ff <= '0;
         begin_ff <= '0;
         frame_ff <= '0;
         vld_ff <= '0;
      end else begin
         state_ff <= state_in;
         begin_ff <= begin_in;
         frame_ff <= frame_in;
         if (clear_all) begin
            vld_ff <= '0;
         end else if (acc_we) begin
            vld_ff[acc_waddr] <= 1'b1;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_TPS:    tps_ff <= csr_data;
               REG_PACING: pacing_ff <= csr_data[3:0];
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_valid = (state_ff == ST_PH_OUT) || (state_ff == ST_SUM_OUT) ||
                      (state_ff == ST_ZERO_OUT);
   assign rsp_kind = kind_ff;
   assign rsp_phase_index = pidx_ff;
   assign rsp_phase_ms_q16 = pms_ff;
   assign rsp_elapsed_s_q16 = els_ff;
   assign rsp_frame_total = ftot_ff;
   assign rsp_fps_q16 = fps_ff;
   assign rsp_active_ms_q16 = ams_ff;
   assign rsp_busy_pct_q16 = bpct_ff;
   assign rsp_untracked_ms_q16 = unt_ff;
   assign rsp_last = last_ff;

endmodule
`default_nettype wire

/* hdl/ptp_unit.sv */
// Bit-serial shared unit: shift-add multiply and restoring divide with 48-bit saturation.
`default_nettype none
module ptp_unit import ptp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  unit_ctl_type        ctl,
   input  logic [NUM_W-1:0]    a_in,
   input  logic [DEN_W-1:0]    b_arg,
   output unit_stat_type       stat,
   output logic [NUM_W-1:0]    prod_out,
   output logic [Q_W-1:0]      quo_out
);

   localparam logic [7:0] MUL_STEPS = 8'(DEN_W);
   localparam logic [7:0] DIV_STEPS = 8'(NUM_W);

   logic [NUM_W-1:0] n_ff, n_in, p_ff, p_in;
   logic [DEN_W-1:0] b_ff, b_in, rem_ff, rem_in, shift_rem;
   logic [Q_W-1:0]   q_ff, q_in;
   logic             sat_ff, sat_in, run_ff, run_in, done_ff, done_in, ge;
   op_type           op_ff, op_in;
   logic [7:0]       cnt_ff, cnt_in;

   assign shift_rem = {rem_ff[DEN_W-2:0], n_ff[NUM_W-1]};
   assign ge = rem_ff[DEN_W-1] | (shift_rem >= b_ff);

   always_comb begin
      n_in = n_ff;
      p_in = p_ff;
      b_in = b_ff;
      rem_in = rem_ff;
      q_in = q_ff;
      sat_in = sat_ff;
      run_in = run_ff;
      op_in = op_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         n_in = a_in;
         b_in = b_arg;
         p_in = '0;
         rem_in = '0;
         q_in = '0;
         sat_in = 1'b0;
         op_in = ctl.op;
         run_in = 1'b1;
         cnt_in = (ctl.op == OP_MUL) ? MUL_STEPS : DIV_STEPS;
      end else if (run_ff) begin
         n_in = {n_ff[NUM_W-2:0], 1'b0};
         if (op_ff == OP_MUL) begin
            if (b_ff[0]) begin
               p_in = p_ff + n_ff;
            end
            b_in = {1'b0, b_ff[DEN_W-1:1]};
         end else begin
            rem_in = ge ? (shift_rem - b_ff) : shift_rem;
            sat_in = sat_ff | q_ff[Q_W-1];
            q_in = {q_ff[Q_W-2:0], ge};
         end
         cnt_in = cnt_ff - 8'd1;
         if (cnt_ff == 8'd1) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;
      p_ff <= p_in;
      b_ff <= b_in;
      rem_ff <= rem_in;
      q_ff <= q_in;
      sat_ff <= sat_in;
      op_ff <= op_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = run_ff;
   assign stat.done = done_ff;
   assign prod_out = p_ff;
   assign quo_out = sat_ff ? {Q_W{1'b1}} : q_ff;

endmodule
`default_nettype wire

/* hdl/ptp_check.sv */
// Port-level checker of the phase tick profiler and its bind.
`default_nettype none
module ptp_check import ptp_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic [47:0] rsp_phase_ms_q16,
   input logic [31:0] rsp_frame_total,
   input logic        rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while a result waits");

   a_phase_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_PHASE |-> !rsp_last)
      else $error("phase line marked last");

   a_other_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_PHASE |-> rsp_last)
      else $error("summary or empty result not marked last");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_NONE |-> rsp_phase_ms_q16 == 48'd0 &&
      rsp_frame_total == 32'd0)
      else $error("empty result carries data");

endmodule

bind phase_tick_profiler ptp_check u_ptp_check (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_kind         (rsp_kind),
   .rsp_phase_ms_q16 (rsp_phase_ms_q16),
   .rsp_frame_total  (rsp_frame_total),
   .rsp_last         (rsp_last)
);
`default_nettype wire
